[sv/quaternion_path_integrator_unit_defines.svh]
// assertion macros used by the quaternion path integrator sequencer
`ifndef QUATERNION_PATH_INTEGRATOR_UNIT_DEFINES_SVH
`define QUATERNION_PATH_INTEGRATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QPI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpi assertion failed");

// next-cycle implication, checked outside reset
`define QPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpi assertion failed");

`endif

[sv/qpi_pkg.sv]
// types, codes and the multiply-accumulate schedule of the path integrator
package qpi_pkg;

    // payload of one input transfer
    typedef struct packed {
        logic               restart;
        logic signed [23:0] delta_x;
        logic signed [23:0] delta_y;
        logic signed [23:0] delta_z;
        logic signed [15:0] turn_w;
        logic signed [15:0] turn_x;
        logic signed [15:0] turn_y;
        logic signed [15:0] turn_z;
    } in_t;

    // payload of one output transfer
    typedef struct packed {
        logic        [15:0] frame_number;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_rot_w;
        logic signed [15:0] out_rot_x;
        logic signed [15:0] out_rot_y;
        logic signed [15:0] out_rot_z;
    } out_t;

    // start pose held in the configuration registers
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
    } start_t;

    // configuration register indexes
    localparam logic [2:0] CFG_START_POS_X = 3'd0;
    localparam logic [2:0] CFG_START_POS_Z = 3'd1;
    localparam logic [2:0] CFG_START_ROT_W = 3'd2;
    localparam logic [2:0] CFG_START_ROT_X = 3'd3;
    localparam logic [2:0] CFG_START_ROT_Y = 3'd4;
    localparam logic [2:0] CFG_START_ROT_Z = 3'd5;

    localparam logic signed [15:0] ROT_ONE = 16'sd16384;

    // multiplier operand a sources
    localparam logic [3:0] A_VX = 4'd0;
    localparam logic [3:0] A_VY = 4'd1;
    localparam logic [3:0] A_VZ = 4'd2;
    localparam logic [3:0] A_TW = 4'd3;
    localparam logic [3:0] A_TX = 4'd4;
    localparam logic [3:0] A_TY = 4'd5;
    localparam logic [3:0] A_TZ = 4'd6;
    localparam logic [3:0] A_AW = 4'd7;
    localparam logic [3:0] A_AX = 4'd8;
    localparam logic [3:0] A_AY = 4'd9;
    localparam logic [3:0] A_AZ = 4'd10;

    // multiplier operand b sources (previous orientation)
    localparam logic [1:0] B_W = 2'd0;
    localparam logic [1:0] B_X = 2'd1;
    localparam logic [1:0] B_Y = 2'd2;
    localparam logic [1:0] B_Z = 2'd3;

    // accumulator destinations
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_TW   = 4'd1;
    localparam logic [3:0] D_TX   = 4'd2;
    localparam logic [3:0] D_TY   = 4'd3;
    localparam logic [3:0] D_TZ   = 4'd4;
    localparam logic [3:0] D_RX   = 4'd5;
    localparam logic [3:0] D_RY   = 4'd6;
    localparam logic [3:0] D_RZ   = 4'd7;
    localparam logic [3:0] D_NW   = 4'd8;
    localparam logic [3:0] D_NX   = 4'd9;
    localparam logic [3:0] D_NY   = 4'd10;
    localparam logic [3:0] D_NZ   = 4'd11;

    localparam int         NUM_STEPS = 40;
    localparam logic [5:0] LAST_STEP = 6'(NUM_STEPS - 1);

    // one multiply-accumulate step
    typedef struct packed {
        logic [3:0] a_sel;
        logic [1:0] b_sel;
        logic       neg;
        logic       first;
        logic [3:0] dst;
    } uop_t;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       issue;
        logic [5:0] step;
        logic       commit;
    } cmd_t;

    function automatic uop_t mk(input logic [3:0] a, input logic [1:0] b,
                                input logic n, input logic f, input logic [3:0] d);
        uop_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.neg   = n;
        u.first = f;
        u.dst   = d;
        return u;
    endfunction

    // t = q*(0,v), r = t*conj(q), n = turn*q
    function automatic uop_t uop_at(input logic [5:0] s);
        uop_t u;
        case (s)
            6'd0:  u = mk(A_VX, B_X, 1'b1, 1'b1, D_NONE);
            6'd1:  u = mk(A_VY, B_Y, 1'b1, 1'b0, D_NONE);
            6'd2:  u = mk(A_VZ, B_Z, 1'b1, 1'b0, D_TW);
            6'd3:  u = mk(A_VX, B_W, 1'b0, 1'b1, D_NONE);
            6'd4:  u = mk(A_VZ, B_Y, 1'b0, 1'b0, D_NONE);
            6'd5:  u = mk(A_VY, B_Z, 1'b1, 1'b0, D_TX);
            6'd6:  u = mk(A_VY, B_W, 1'b0, 1'b1, D_NONE);
            6'd7:  u = mk(A_VX, B_Z, 1'b0, 1'b0, D_NONE);
            6'd8:  u = mk(A_VZ, B_X, 1'b1, 1'b0, D_TY);
            6'd9:  u = mk(A_VZ, B_W, 1'b0, 1'b1, D_NONE);
            6'd10: u = mk(A_VY, B_X, 1'b0, 1'b0, D_NONE);
            6'd11: u = mk(A_VX, B_Y, 1'b1, 1'b0, D_TZ);
            6'd12: u = mk(A_TW, B_X, 1'b1, 1'b1, D_NONE);
            6'd13: u = mk(A_TX, B_W, 1'b0, 1'b0, D_NONE);
            6'd14: u = mk(A_TY, B_Z, 1'b1, 1'b0, D_NONE);
            6'd15: u = mk(A_TZ, B_Y, 1'b0, 1'b0, D_RX);
            6'd16: u = mk(A_TW, B_Y, 1'b1, 1'b1, D_NONE);
            6'd17: u = mk(A_TX, B_Z, 1'b0, 1'b0, D_NONE);
            6'd18: u = mk(A_TY, B_W, 1'b0, 1'b0, D_NONE);
            6'd19: u = mk(A_TZ, B_X, 1'b1, 1'b0, D_RY);
            6'd20: u = mk(A_TW, B_Z, 1'b1, 1'b1, D_NONE);
            6'd21: u = mk(A_TX, B_Y, 1'b1, 1'b0, D_NONE);
            6'd22: u = mk(A_TY, B_X, 1'b0, 1'b0, D_NONE);
            6'd23: u = mk(A_TZ, B_W, 1'b0, 1'b0, D_RZ);
            6'd24: u = mk(A_AW, B_W, 1'b0, 1'b1, D_NONE);
            6'd25: u = mk(A_AX, B_X, 1'b1, 1'b0, D_NONE);
            6'd26: u = mk(A_AY, B_Y, 1'b1, 1'b0, D_NONE);
            6'd27: u = mk(A_AZ, B_Z, 1'b1, 1'b0, D_NW);
            6'd28: u = mk(A_AW, B_X, 1'b0, 1'b1, D_NONE);
            6'd29: u = mk(A_AX, B_W, 1'b0, 1'b0, D_NONE);
            6'd30: u = mk(A_AY, B_Z, 1'b0, 1'b0, D_NONE);
            6'd31: u = mk(A_AZ, B_Y, 1'b1, 1'b0, D_NX);
            6'd32: u = mk(A_AW, B_Y, 1'b0, 1'b1, D_NONE);
            6'd33: u = mk(A_AX, B_Z, 1'b1, 1'b0, D_NONE);
            6'd34: u = mk(A_AY, B_W, 1'b0, 1'b0, D_NONE);
            6'd35: u = mk(A_AZ, B_X, 1'b0, 1'b0, D_NY);
            6'd36: u = mk(A_AW, B_Z, 1'b0, 1'b1, D_NONE);
            6'd37: u = mk(A_AX, B_Y, 1'b0, 1'b0, D_NONE);
            6'd38: u = mk(A_AY, B_X, 1'b1, 1'b0, D_NONE);
            6'd39: u = mk(A_AZ, B_W, 1'b0, 1'b0, D_NZ);
            default: u = mk(A_VX, B_W, 1'b0, 1'b1, D_NONE);
        endcase
        return u;
    endfunction

endpackage

[sv/qpi_cfg_regs.sv]
// start pose configuration registers
module qpi_cfg_regs
    import qpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    output start_t      start
);

    start_t start_reg;
    start_t start_next;

    // register write decode, unknown indexes dropped
    always_comb
    begin
        start_next = start_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_START_POS_X: start_next.pos_x = wr_data;
                CFG_START_POS_Z: start_next.pos_z = wr_data;
                CFG_START_ROT_W: start_next.rot_w = wr_data[15:0];
                CFG_START_ROT_X: start_next.rot_x = wr_data[15:0];
                CFG_START_ROT_Y: start_next.rot_y = wr_data[15:0];
                CFG_START_ROT_Z: start_next.rot_z = wr_data[15:0];
                default: start_next = start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg.pos_x <= '0;
            start_reg.pos_z <= '0;
            start_reg.rot_w <= ROT_ONE;
            start_reg.rot_x <= '0;
            start_reg.rot_y <= '0;
            start_reg.rot_z <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    assign start = start_reg;

endmodule

[sv/qpi_datapath.sv]
// shared multiplier, accumulator, intermediate and pose registers
module qpi_datapath
    import qpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  in_t  in_data,
    input  start_t start,
    output out_t out_data
);

    // captured item
    in_t item_reg;

    // pose state
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] rot_w_reg, rot_x_reg, rot_y_reg, rot_z_reg;
    logic        [15:0] frame_reg;

    // intermediates
    logic signed [41:0] tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    logic signed [19:0] nw_reg, nx_reg, ny_reg, nz_reg;

    // multiplier and accumulator
    logic signed [41:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [57:0] prod;
    logic signed [57:0] prod_reg;
    uop_t               uop_cur;
    uop_t               uop_d_reg;
    logic               acc_vld_reg;
    logic signed [61:0] acc_reg;
    logic signed [61:0] acc_next;
    logic signed [61:0] acc_base;
    logic signed [61:0] bias;

    // pose seen by this item, start pose when restarting
    logic signed [31:0] px_eff, py_eff, pz_eff;
    logic signed [15:0] qw, qx, qy, qz;
    logic        [15:0] frame_eff;

    // commit values
    logic signed [32:0] sum_x, sum_y, sum_z;
    logic signed [31:0] px_new, py_new, pz_new;
    logic signed [15:0] rw_new, rx_new, ry_new, rz_new;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sh07FFF)
            r = 16'sh7FFF;
        else if (v < -20'sh08000)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // effective previous pose
    always_comb
    begin
        px_eff    = item_reg.restart ? start.pos_x : pos_x_reg;
        py_eff    = item_reg.restart ? 32'sd0 : pos_y_reg;
        pz_eff    = item_reg.restart ? start.pos_z : pos_z_reg;
        qw        = item_reg.restart ? start.rot_w : rot_w_reg;
        qx        = item_reg.restart ? start.rot_x : rot_x_reg;
        qy        = item_reg.restart ? start.rot_y : rot_y_reg;
        qz        = item_reg.restart ? start.rot_z : rot_z_reg;
        frame_eff = item_reg.restart ? 16'd0 : frame_reg;
    end

    // operand selection
    always_comb
    begin
        uop_cur = uop_at(cmd.step);
        case (uop_cur.a_sel)
            A_VX: mul_a = {{18{item_reg.delta_x[23]}}, item_reg.delta_x};
            A_VY: mul_a = {{18{item_reg.delta_y[23]}}, item_reg.delta_y};
            A_VZ: mul_a = {{18{item_reg.delta_z[23]}}, item_reg.delta_z};
            A_TW: mul_a = tw_reg;
            A_TX: mul_a = tx_reg;
            A_TY: mul_a = ty_reg;
            A_TZ: mul_a = tz_reg;
            A_AW: mul_a = {{26{item_reg.turn_w[15]}}, item_reg.turn_w};
            A_AX: mul_a = {{26{item_reg.turn_x[15]}}, item_reg.turn_x};
            A_AY: mul_a = {{26{item_reg.turn_y[15]}}, item_reg.turn_y};
            A_AZ: mul_a = {{26{item_reg.turn_z[15]}}, item_reg.turn_z};
            default: mul_a = '0;
        endcase
        case (uop_cur.b_sel)
            B_W: mul_b = qw;
            B_X: mul_b = qx;
            B_Y: mul_b = qy;
            B_Z: mul_b = qz;
            default: mul_b = qw;
        endcase
        prod = mul_a * mul_b;
    end

    // accumulate with rounding bias folded into the first term
    always_comb
    begin
        case (uop_d_reg.a_sel)
            A_TW, A_TX, A_TY, A_TZ: bias = 62'sd1 <<< 27;
            A_AW, A_AX, A_AY, A_AZ: bias = 62'sd1 <<< 13;
            default: bias = '0;
        endcase
        acc_base = uop_d_reg.first ? bias : acc_reg;
        if (uop_d_reg.neg)
            acc_next = acc_base - {{4{prod_reg[57]}}, prod_reg};
        else
            acc_next = acc_base + {{4{prod_reg[57]}}, prod_reg};
    end

    // multiplier output register and delayed step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.issue)
        begin
            prod_reg  <= prod;
            uop_d_reg <= uop_cur;
        end
        if (acc_vld_reg)
        begin
            acc_reg <= acc_next;
            case (uop_d_reg.dst)
                D_TW: tw_reg <= acc_next[41:0];
                D_TX: tx_reg <= acc_next[41:0];
                D_TY: ty_reg <= acc_next[41:0];
                D_TZ: tz_reg <= acc_next[41:0];
                D_RX: rx_reg <= acc_next[59:28];
                D_RY: ry_reg <= acc_next[59:28];
                D_RZ: rz_reg <= acc_next[59:28];
                D_NW: nw_reg <= acc_next[33:14];
                D_NX: nx_reg <= acc_next[33:14];
                D_NY: ny_reg <= acc_next[33:14];
                D_NZ: nz_reg <= acc_next[33:14];
                default: ;
            endcase
        end
    end

    // position add and saturation
    always_comb
    begin
        sum_x  = {px_eff[31], px_eff} + {rx_reg[31], rx_reg};
        sum_y  = {py_eff[31], py_eff} + {ry_reg[31], ry_reg};
        sum_z  = {pz_eff[31], pz_eff} + {rz_reg[31], rz_reg};
        px_new = sat32(sum_x);
        py_new = sat32(sum_y);
        pz_new = sat32(sum_z);
        rw_new = sat16(nw_reg);
        rx_new = sat16(nx_reg);
        ry_new = sat16(ny_reg);
        rz_new = sat16(nz_reg);
    end

    // pose state, also the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            rot_w_reg <= ROT_ONE;
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
            frame_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pos_x_reg <= px_new;
            pos_y_reg <= py_new;
            pos_z_reg <= pz_new;
            rot_w_reg <= rw_new;
            rot_x_reg <= rx_new;
            rot_y_reg <= ry_new;
            rot_z_reg <= rz_new;
            frame_reg <= frame_eff + 16'd1;
        end
    end

    always_comb
    begin
        out_data.frame_number = frame_reg;
        out_data.out_pos_x    = pos_x_reg;
        out_data.out_pos_y    = pos_y_reg;
        out_data.out_pos_z    = pos_z_reg;
        out_data.out_rot_w    = rot_w_reg;
        out_data.out_rot_x    = rot_x_reg;
        out_data.out_rot_y    = rot_y_reg;
        out_data.out_rot_z    = rot_z_reg;
    end

endmodule

[sv/qpi_ctrl.sv]
// sequencer for the multiply-accumulate schedule and the output handshake
`include "quaternion_path_integrator_unit_defines.svh"

module qpi_ctrl
    import qpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       commit;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign commit = (state_reg == ST_WAIT) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_DRAIN: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid: set by commit, cleared by transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = accept;
    assign cmd.issue   = (state_reg == ST_RUN);
    assign cmd.step    = step_reg;
    assign cmd.commit  = commit;

    `QPI_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_reg)
    `QPI_ASSERT_NOW(a_commit_no_overwrite, commit, !out_valid_reg || !out_stall)
    `QPI_ASSERT_NEXT(a_accept_starts_at_zero, accept, step_reg == 6'd0 && state_reg == ST_RUN)

endmodule

[sv/quaternion_path_integrator_unit.sv]
// Quaternion dead-reckoning path integrator, top level.
// Input channel in_valid/in_stall/in_data: one frame with a local
// displacement (Q15.8) and an incremental rotation (Q1.14); restart set
// loads the start pose and clears the frame count before the frame.
// Output channel out_valid/out_stall/out_data: frame number, new position
// (Q23.8, saturated) and new orientation (Q1.14, saturated), one per frame.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the start
// pose registers; cfg_ready is always high, unknown indexes are dropped.
// Each frame runs the 40 multiply-accumulate steps on the single shared
// 42x16 multiplier, then pipeline drain and commit; in_stall is high
// from the input transfer until that commit.
// A new frame is accepted while the previous result still waits; its
// commit waits until that result has been transferred.
// Reset: pose is zero position with identity orientation, frame count 0,
// start pose registers likewise, no result pending.
module quaternion_path_integrator_unit
    import qpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t   cmd;
    start_t start;

    assign cfg_ready = 1'b1;

    // start pose registers
    qpi_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .start    (start)
    );

    // sequencer
    qpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and pose state
    qpi_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .start    (start),
        .out_data (out_data)
    );

endmodule
